@@ rtl/core/mpeg_audio_header_sync_parse_unit_macros.svh @@
// Assertion macros used by the checker file of the header sync parser.
`ifndef MPEG_AUDIO_HEADER_SYNC_PARSE_UNIT_MACROS_SVH
`define MPEG_AUDIO_HEADER_SYNC_PARSE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MAHSP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mahsp assertion failed");

// Next-cycle implication, disabled during reset.
`define MAHSP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mahsp assertion failed");

`endif

@@ rtl/core/mahsp_pkg.sv @@
// Types and constants of the MPEG audio header sync parser.
`default_nettype none
package mahsp_pkg;

    typedef logic [31:0] hdr_word_t;
    typedef logic [1:0]  win_fill_t;

    localparam win_fill_t WIN_FULL     = 2'd3;
    localparam logic [7:0] SYNC_BYTE   = 8'hFF;
    localparam logic [7:0] SYNC_MASK   = 8'hE0;
    localparam logic [3:0] RATE_IDX_BAD = 4'hF;
    localparam logic [3:0] RATE_IDX_PEAK = 4'd14;
    localparam logic [1:0] FREQ_IDX_BAD = 2'd3;
    localparam logic [1:0] EMPH_BAD    = 2'd2;
    localparam logic [1:0] LAYER_RSVD  = 2'd0;
    localparam logic [1:0] LAYER_ONE   = 2'd3;
    localparam logic [1:0] LAYER_THREE = 2'd1;
    localparam logic [1:0] MODE_SINGLE = 2'd3;

    localparam logic [1:0] VER_MPEG1  = 2'd0;
    localparam logic [1:0] VER_MPEG2  = 2'd1;
    localparam logic [1:0] VER_MPEG25 = 2'd2;

    localparam int OUT_BITS  = 50;
    localparam int OUT_BYTES = 7;

    typedef struct packed {
        logic [1:0]  emphasis_code;
        logic [1:0]  rights_flags;
        logic [1:0]  stereo_ext;
        logic [1:0]  channel_count;
        logic [1:0]  channel_mode;
        logic        padding_flag;
        logic [15:0] sample_rate_hz;
        logic [8:0]  peak_bit_rate_kbps;
        logic [8:0]  bit_rate_kbps;
        logic        crc_present;
        logic [1:0]  layer_number;
        logic [1:0]  version_code;
    } hdr_fields_t;

endpackage
`default_nettype wire

@@ rtl/core/mahsp_front.sv @@
// Front end: byte window, sync search and header validity check.
`default_nettype none
module mahsp_front
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [7:0]          s_axis_tdata,   // data_byte[7:0]
    input  wire logic                s_axis_tuser,   // buffer_start
    output logic                     push_valid,
    output mahsp_pkg::hdr_word_t     push_word,
    input  wire logic                push_ready
);

    logic [7:0]           win_reg  [3];
    logic [7:0]           win_next [3];
    mahsp_pkg::win_fill_t fill_reg;
    mahsp_pkg::win_fill_t fill_next;
    mahsp_pkg::win_fill_t fill_cur;
    logic                 accept;
    logic                 sync_ok;
    logic                 hdr_ok;

    assign s_axis_tready = push_ready;
    assign accept        = s_axis_tvalid && push_ready;
    assign push_word     = {win_reg[0], win_reg[1], win_reg[2], s_axis_tdata};

    always_comb
    begin
        sync_ok = (win_reg[0] == mahsp_pkg::SYNC_BYTE) &&
                  ((win_reg[1] & mahsp_pkg::SYNC_MASK) == mahsp_pkg::SYNC_MASK);
        hdr_ok  = sync_ok &&
                  !(!push_word[20] && push_word[19]) &&
                  (push_word[18:17] != mahsp_pkg::LAYER_RSVD) &&
                  (push_word[18:17] != mahsp_pkg::LAYER_ONE) &&
                  (push_word[15:12] != mahsp_pkg::RATE_IDX_BAD) &&
                  (push_word[11:10] != mahsp_pkg::FREQ_IDX_BAD) &&
                  (push_word[1:0] != mahsp_pkg::EMPH_BAD);
    end

    always_comb
    begin
        fill_cur   = s_axis_tuser ? '0 : fill_reg;
        win_next   = win_reg;
        fill_next  = fill_reg;
        push_valid = 1'b0;
        if (accept)
        begin
            if (fill_cur != mahsp_pkg::WIN_FULL)
            begin
                win_next[fill_cur] = s_axis_tdata;
                fill_next          = fill_cur + 2'd1;
            end
            else if (hdr_ok)
            begin
                push_valid = 1'b1;
                fill_next  = '0;
            end
            else
            begin
                win_next[0] = win_reg[1];
                win_next[1] = win_reg[2];
                win_next[2] = s_axis_tdata;
                fill_next   = mahsp_pkg::WIN_FULL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            win_reg  <= '{default: '0};
        end
        else
        begin
            fill_reg <= fill_next;
            win_reg  <= win_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/mahsp_queue.sv @@
// Header word queue between the front end and the decoder.
`default_nettype none
module mahsp_queue
#(
    parameter int DEPTH = 2
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push_valid,
    input  wire mahsp_pkg::hdr_word_t push_word,
    output logic                      push_ready,
    output logic                      pop_valid,
    output mahsp_pkg::hdr_word_t      pop_word,
    input  wire logic                 pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mahsp_pkg::hdr_word_t entry_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_word   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/mahsp_back.sv @@
// Back end: table decode of a valid header word into the output register.
`default_nettype none
module mahsp_back
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 pop_valid,
    input  wire mahsp_pkg::hdr_word_t pop_word,
    output logic                      pop_ready,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output mahsp_pkg::hdr_fields_t    out_fields
);

    logic                   out_valid_reg;
    logic                   out_valid_next;
    mahsp_pkg::hdr_fields_t out_data_reg;
    mahsp_pkg::hdr_fields_t dec;
    logic                   load;
    logic                   row_lsf;
    logic                   layer3;

    function automatic logic [8:0] rate_lookup(input logic lsf, input logic l3,
                                               input logic [3:0] idx);
        logic [8:0] r;
        r = '0;
        if (lsf)
        begin
            unique case (idx)
                4'd1:    r = 9'd8;
                4'd2:    r = 9'd16;
                4'd3:    r = 9'd24;
                4'd4:    r = 9'd32;
                4'd5:    r = 9'd40;
                4'd6:    r = 9'd48;
                4'd7:    r = 9'd56;
                4'd8:    r = 9'd64;
                4'd9:    r = 9'd80;
                4'd10:   r = 9'd96;
                4'd11:   r = 9'd112;
                4'd12:   r = 9'd128;
                4'd13:   r = 9'd144;
                4'd14:   r = 9'd160;
                default: r = 9'd0;
            endcase
        end
        else if (l3)
        begin
            unique case (idx)
                4'd1:    r = 9'd32;
                4'd2:    r = 9'd40;
                4'd3:    r = 9'd48;
                4'd4:    r = 9'd56;
                4'd5:    r = 9'd64;
                4'd6:    r = 9'd80;
                4'd7:    r = 9'd96;
                4'd8:    r = 9'd112;
                4'd9:    r = 9'd128;
                4'd10:   r = 9'd160;
                4'd11:   r = 9'd192;
                4'd12:   r = 9'd224;
                4'd13:   r = 9'd256;
                4'd14:   r = 9'd320;
                default: r = 9'd0;
            endcase
        end
        else
        begin
            unique case (idx)
                4'd1:    r = 9'd32;
                4'd2:    r = 9'd48;
                4'd3:    r = 9'd56;
                4'd4:    r = 9'd64;
                4'd5:    r = 9'd80;
                4'd6:    r = 9'd96;
                4'd7:    r = 9'd112;
                4'd8:    r = 9'd128;
                4'd9:    r = 9'd160;
                4'd10:   r = 9'd192;
                4'd11:   r = 9'd224;
                4'd12:   r = 9'd256;
                4'd13:   r = 9'd320;
                4'd14:   r = 9'd384;
                default: r = 9'd0;
            endcase
        end
        return r;
    endfunction

    function automatic logic [15:0] hz_lookup(input logic [1:0] ver, input logic [1:0] idx);
        logic [15:0] h;
        h = '0;
        unique case (ver)
            mahsp_pkg::VER_MPEG1:
            begin
                unique case (idx)
                    2'd0:    h = 16'd44100;
                    2'd1:    h = 16'd48000;
                    default: h = 16'd32000;
                endcase
            end
            mahsp_pkg::VER_MPEG2:
            begin
                unique case (idx)
                    2'd0:    h = 16'd22050;
                    2'd1:    h = 16'd24000;
                    default: h = 16'd16000;
                endcase
            end
            default:
            begin
                unique case (idx)
                    2'd0:    h = 16'd11025;
                    2'd1:    h = 16'd12000;
                    default: h = 16'd8000;
                endcase
            end
        endcase
        return h;
    endfunction

    assign load          = pop_valid && (!out_valid_reg || m_axis_tready);
    assign pop_ready     = load;
    assign m_axis_tvalid = out_valid_reg;
    assign out_fields    = out_data_reg;

    always_comb
    begin
        row_lsf = !pop_word[19];
        layer3  = (pop_word[18:17] == mahsp_pkg::LAYER_THREE);
        if (!pop_word[20])
        begin
            dec.version_code = mahsp_pkg::VER_MPEG25;
        end
        else if (pop_word[19])
        begin
            dec.version_code = mahsp_pkg::VER_MPEG1;
        end
        else
        begin
            dec.version_code = mahsp_pkg::VER_MPEG2;
        end
        dec.layer_number       = layer3 ? 2'd3 : 2'd2;
        dec.crc_present        = !pop_word[16];
        dec.bit_rate_kbps      = rate_lookup(row_lsf, layer3, pop_word[15:12]);
        dec.peak_bit_rate_kbps = rate_lookup(row_lsf, layer3, mahsp_pkg::RATE_IDX_PEAK);
        dec.sample_rate_hz     = hz_lookup(dec.version_code, pop_word[11:10]);
        dec.padding_flag       = pop_word[9];
        dec.channel_mode       = pop_word[7:6];
        dec.channel_count      = (pop_word[7:6] == mahsp_pkg::MODE_SINGLE) ? 2'd1 : 2'd2;
        dec.stereo_ext         = pop_word[5:4];
        dec.rights_flags       = pop_word[3:2];
        dec.emphasis_code      = pop_word[1:0];
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= dec;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/mpeg_audio_header_sync_parse_unit.sv @@
// Top level of the MPEG audio frame header sync and parse unit.
// Input channel s_axis: one stream byte per transaction in tdata; tuser set marks the
//   first byte of a new buffer and empties the four-byte search window before it.
// Output channel m_axis: one transaction per valid frame header, all decoded fields
//   packed in tdata. Bytes that never complete a valid header produce nothing.
// Throughput: one byte per cycle while the header queue has room (s_axis_tready is its
//   push_ready); the decoder retires one header per cycle unless the output stalls.
// Path: the transaction that carries the fourth header byte writes the header queue; the
//   output register then loads the word from the queue and m_axis_tvalid rises with it.
// Reset: empties the window, the header queue and the output register.
// Stall: while m_axis_tready is low the output register holds its header and later
//   headers fill the queue; s_axis_tready drops only once the queue is full.
`default_nettype none
module mpeg_audio_header_sync_parse_unit
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  wire logic        s_axis_tuser,   // buffer_start
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // version_code[1:0], layer_number[3:2], crc_present[4], bit_rate_kbps[13:5],
    // peak_bit_rate_kbps[22:14], sample_rate_hz[38:23], padding_flag[39],
    // channel_mode[41:40], channel_count[43:42], stereo_ext[45:44],
    // rights_flags[47:46], emphasis_code[49:48], zero[55:50]
    output logic [8*mahsp_pkg::OUT_BYTES-1:0] m_axis_tdata
);

    logic                   push_valid;
    logic                   push_ready;
    mahsp_pkg::hdr_word_t   push_word;
    logic                   pop_valid;
    logic                   pop_ready;
    mahsp_pkg::hdr_word_t   pop_word;
    mahsp_pkg::hdr_fields_t out_fields;

    mahsp_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push_valid    (push_valid),
        .push_word     (push_word),
        .push_ready    (push_ready)
    );

    mahsp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_word  (push_word),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_word   (pop_word),
        .pop_ready  (pop_ready)
    );

    mahsp_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_word      (pop_word),
        .pop_ready     (pop_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .out_fields    (out_fields)
    );

    assign m_axis_tdata = {(8*mahsp_pkg::OUT_BYTES - mahsp_pkg::OUT_BITS)'(0), out_fields};

endmodule
`default_nettype wire

@@ rtl/core/mahsp_checker.sv @@
// Port-level checker of the header sync parse unit and its bind.
`default_nettype none
`include "mpeg_audio_header_sync_parse_unit_macros.svh"
module mahsp_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [55:0] m_axis_tdata
);

    logic out_stall;
    logic out_idle;
    logic hdr_legal;
    logic count_ok;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_idle  = !m_axis_tvalid;
    assign hdr_legal = ((m_axis_tdata[3:2] == 2'd2) || (m_axis_tdata[3:2] == 2'd3)) &&
                       (m_axis_tdata[49:48] != mahsp_pkg::EMPH_BAD) &&
                       (m_axis_tdata[55:50] == 6'd0);
    assign count_ok  = m_axis_tdata[43:42] ==
                       ((m_axis_tdata[41:40] == mahsp_pkg::MODE_SINGLE) ? 2'd1 : 2'd2);

    `MAHSP_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
    `MAHSP_ASSERT_IMP(a_layer_emph, clk, rst_n, m_axis_tvalid, hdr_legal)
    `MAHSP_ASSERT_IMP(a_chan_count, clk, rst_n, m_axis_tvalid, count_ok)
    `MAHSP_ASSERT_NXT(a_no_spurious, clk, rst_n, out_idle && !$past(s_axis_tvalid), out_idle)

endmodule

bind mpeg_audio_header_sync_parse_unit mahsp_checker u_mahsp_checker (.*);
`default_nettype wire

@@ sim/mpeg_audio_header_sync_parse_unit_test.sv @@
// Self-checking testbench for the MPEG audio header sync and parse unit.
`timescale 1ns / 100ps

module mpeg_audio_header_sync_parse_unit_test;

    localparam int RAND_ITEMS  = 1700;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_AT    = 900;
    localparam int MAX_REPORTS = 10;
    localparam int HDR_W       = $bits(mahsp_pkg::hdr_fields_t);
    localparam int TDATA_W     = 8*mahsp_pkg::OUT_BYTES;

    localparam logic [1:0] VER_BITS_RSVD = 2'b01;

    localparam logic [8:0] KBPS [2][2][16] = '{
        '{'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
            9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
          '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
            9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0}},
        '{'{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
            9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
          '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
            9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}}
    };

    localparam logic [15:0] HZ [2][3] = '{
        '{16'd44100, 16'd48000, 16'd32000},
        '{16'd22050, 16'd24000, 16'd16000}
    };

    localparam mahsp_pkg::hdr_fields_t NO_HDR = '0;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_t;

    typedef struct packed {
        logic [7:0]             data;
        logic                   st;
        logic                   typed;
        mahsp_pkg::hdr_fields_t hdr;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;

    logic [7:0]           win_q [3] = '{8'h00, 8'h00, 8'h00};
    mahsp_pkg::win_fill_t win_n     = '0;

    mahsp_pkg::hdr_fields_t pending_headers [$];
    int          err_count   = 0;
    int          n_in        = 0;
    int          burst_left  = 0;
    int          cycle_count = 0;

    mpeg_audio_header_sync_parse_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("mpeg_audio_header_sync_parse_unit_test: done, errors");
        $finish;
    end

    function automatic mahsp_pkg::hdr_fields_t mk_hdr(input logic [1:0] ver, input int layer,
                                           input int crc, input int br, input int peak,
                                           input int hz, input int pad, input int mode,
                                           input int chans, input int mext,
                                           input int rights, input int emph);
        mahsp_pkg::hdr_fields_t h;
        h.version_code       = ver;
        h.layer_number       = 2'(layer);
        h.crc_present        = 1'(crc);
        h.bit_rate_kbps      = 9'(br);
        h.peak_bit_rate_kbps = 9'(peak);
        h.sample_rate_hz     = 16'(hz);
        h.padding_flag       = 1'(pad);
        h.channel_mode       = 2'(mode);
        h.channel_count      = 2'(chans);
        h.stereo_ext         = 2'(mext);
        h.rights_flags       = 2'(rights);
        h.emphasis_code      = 2'(emph);
        return h;
    endfunction

    // Slide the window by one byte; return 1 with the decoded header on a valid frame start.
    function automatic bit sync_parse_byte(input logic [7:0] b, input logic st,
                                           output mahsp_pkg::hdr_fields_t h);
        logic [31:0] w;
        logic [1:0]  lay;
        logic [1:0]  fidx;
        logic [3:0]  ridx;
        logic        row;
        logic        lcol;
        logic [15:0] hz;
        bit          ok;
        h = '0;
        if (st)
            win_n = '0;
        if (win_n != mahsp_pkg::WIN_FULL)
        begin
            win_q[win_n] = b;
            win_n = win_n + 2'd1;
            return 1'b0;
        end
        w    = {win_q[0], win_q[1], win_q[2], b};
        lay  = w[18:17];
        ridx = w[15:12];
        fidx = w[11:10];
        ok = win_q[0] == mahsp_pkg::SYNC_BYTE
             && (win_q[1] & mahsp_pkg::SYNC_MASK) == mahsp_pkg::SYNC_MASK
             && w[20:19] != VER_BITS_RSVD
             && lay != mahsp_pkg::LAYER_RSVD && lay != mahsp_pkg::LAYER_ONE
             && ridx != mahsp_pkg::RATE_IDX_BAD && fidx != mahsp_pkg::FREQ_IDX_BAD
             && w[1:0] != mahsp_pkg::EMPH_BAD;
        if (ok)
        begin
            row  = ~w[19];
            lcol = (lay == mahsp_pkg::LAYER_THREE);
            hz   = HZ[row][fidx];
            if (!w[20])
            begin
                h.version_code = mahsp_pkg::VER_MPEG25;
                hz = hz >> 1;
            end
            else if (w[19])
                h.version_code = mahsp_pkg::VER_MPEG1;
            else
                h.version_code = mahsp_pkg::VER_MPEG2;
            h.layer_number       = lcol ? 2'd3 : 2'd2;
            h.crc_present        = ~w[16];
            h.bit_rate_kbps      = KBPS[row][lcol][ridx];
            h.peak_bit_rate_kbps = KBPS[row][lcol][mahsp_pkg::RATE_IDX_PEAK];
            h.sample_rate_hz     = hz;
            h.padding_flag       = w[9];
            h.channel_mode       = w[7:6];
            h.channel_count      = (w[7:6] == mahsp_pkg::MODE_SINGLE) ? 2'd1 : 2'd2;
            h.stereo_ext         = w[5:4];
            h.rights_flags       = w[3:2];
            h.emphasis_code      = w[1:0];
            win_n = '0;
            return 1'b1;
        end
        win_q[0] = win_q[1];
        win_q[1] = win_q[2];
        win_q[2] = b;
        win_n    = mahsp_pkg::WIN_FULL;
        return 1'b0;
    endfunction

    task automatic feed_byte(input logic [7:0] b, input logic st, input logic typed,
                             input mahsp_pkg::hdr_fields_t typed_hdr);
        mahsp_pkg::hdr_fields_t h;
        bit          got;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= st;
        do @(posedge clk); while (!s_axis_tready);
        n_in++;
        got = sync_parse_byte(b, st, h);
        if (typed)
            pending_headers.push_back(typed_hdr);
        else if (got)
            pending_headers.push_back(h);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending_headers.size() != 0);
    endtask

    task automatic note_bad(input string what, input longint exp_v, input longint act_v);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("mismatch %s: expected %0d, got %0d", what, exp_v, act_v);
    endtask

    initial
    begin
        rx_mode_t rx_mode;
        int       mode_left;
        int       hold_left;
        bit       hold_done;
        int       rx_tick;
        rx_mode   = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        rx_tick   = 0;
        while (!rst_n) @(posedge clk);
        forever
        begin
            @(posedge clk);
            rx_tick++;
            if (!hold_done && n_in >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(8, 80);
                end
                mode_left--;
                case (rx_mode)
                    RX_OPEN:   m_axis_tready <= 1'b1;
                    RX_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
                    RX_SPARSE: m_axis_tready <= ($urandom_range(0, 4) == 0);
                    default:   m_axis_tready <= ((rx_tick % 4) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        mahsp_pkg::hdr_fields_t got;
        mahsp_pkg::hdr_fields_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[HDR_W-1:0];
            if (m_axis_tdata[TDATA_W-1:HDR_W] !== '0)
                note_bad("tdata padding", 0, m_axis_tdata[TDATA_W-1:HDR_W]);
            if (pending_headers.size() == 0)
                note_bad("unexpected header", 0, got);
            else
            begin
                want = pending_headers.pop_front();
                if (got.version_code !== want.version_code)
                    note_bad("version_code", want.version_code, got.version_code);
                if (got.layer_number !== want.layer_number)
                    note_bad("layer_number", want.layer_number, got.layer_number);
                if (got.crc_present !== want.crc_present)
                    note_bad("crc_present", want.crc_present, got.crc_present);
                if (got.bit_rate_kbps !== want.bit_rate_kbps)
                    note_bad("bit_rate_kbps", want.bit_rate_kbps, got.bit_rate_kbps);
                if (got.peak_bit_rate_kbps !== want.peak_bit_rate_kbps)
                    note_bad("peak_bit_rate_kbps", want.peak_bit_rate_kbps,
                             got.peak_bit_rate_kbps);
                if (got.sample_rate_hz !== want.sample_rate_hz)
                    note_bad("sample_rate_hz", want.sample_rate_hz, got.sample_rate_hz);
                if (got.padding_flag !== want.padding_flag)
                    note_bad("padding_flag", want.padding_flag, got.padding_flag);
                if (got.channel_mode !== want.channel_mode)
                    note_bad("channel_mode", want.channel_mode, got.channel_mode);
                if (got.channel_count !== want.channel_count)
                    note_bad("channel_count", want.channel_count, got.channel_count);
                if (got.stereo_ext !== want.stereo_ext)
                    note_bad("stereo_ext", want.stereo_ext, got.stereo_ext);
                if (got.rights_flags !== want.rights_flags)
                    note_bad("rights_flags", want.rights_flags, got.rights_flags);
                if (got.emphasis_code !== want.emphasis_code)
                    note_bad("emphasis_code", want.emphasis_code, got.emphasis_code);
            end
        end
    end

    initial
    begin
        dir_row_t    dir_tab [$];
        mahsp_pkg::hdr_fields_t h_m1_l3;
        mahsp_pkg::hdr_fields_t h_m25_l2;
        mahsp_pkg::hdr_fields_t h_m2_free;
        mahsp_pkg::hdr_fields_t h_m1_l2;
        logic [1:0]  ver_b;
        logic [1:0]  lay_b;
        logic [3:0]  ridx;
        logic [1:0]  fidx;
        logic [1:0]  emph;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [31:0] r;
        int          kind;
        int          nfill;
        int          pick;
        bit          mid_drain_done;
        int          stop_at;

        h_m1_l3   = mk_hdr(mahsp_pkg::VER_MPEG1, 3, 0, 128, 320, 44100, 0, 1, 2, 2, 1, 0);
        h_m25_l2  = mk_hdr(mahsp_pkg::VER_MPEG25, 2, 1, 160, 160, 8000, 1, 3, 1, 3, 3, 3);
        h_m2_free = mk_hdr(mahsp_pkg::VER_MPEG2, 3, 1, 0, 160, 16000, 0, 3, 1, 0, 0, 1);
        h_m1_l2   = mk_hdr(mahsp_pkg::VER_MPEG1, 2, 0, 384, 384, 48000, 0, 0, 2, 0, 0, 0);

        dir_tab = '{
            // reserved layer, sync miss, then MPEG-1 layer III
            '{8'hFF, 1'b0, 1'b0, NO_HDR}, '{8'hE1, 1'b0, 1'b0, NO_HDR},
            '{8'hFF, 1'b0, 1'b0, NO_HDR}, '{8'hFB, 1'b0, 1'b0, NO_HDR},
            '{8'h90, 1'b0, 1'b0, NO_HDR}, '{8'h64, 1'b0, 1'b1, h_m1_l3},
            // reserved version, sync miss, then MPEG-2.5 layer II with every flag set
            '{8'hFF, 1'b0, 1'b0, NO_HDR}, '{8'hEB, 1'b0, 1'b0, NO_HDR},
            '{8'hFF, 1'b0, 1'b0, NO_HDR}, '{8'hE4, 1'b0, 1'b0, NO_HDR},
            '{8'hEB, 1'b0, 1'b0, NO_HDR}, '{8'hFF, 1'b0, 1'b1, h_m25_l2},
            // bad rate index, bad sample index, bad emphasis, buffer start, free format
            '{8'hFF, 1'b0, 1'b0, NO_HDR}, '{8'hF2, 1'b0, 1'b0, NO_HDR},
            '{8'hFF, 1'b0, 1'b0, NO_HDR}, '{8'hF2, 1'b0, 1'b0, NO_HDR},
            '{8'h0C, 1'b0, 1'b0, NO_HDR}, '{8'hFF, 1'b0, 1'b0, NO_HDR},
            '{8'hF2, 1'b0, 1'b0, NO_HDR}, '{8'h08, 1'b0, 1'b0, NO_HDR},
            '{8'hC2, 1'b0, 1'b0, NO_HDR}, '{8'hFF, 1'b1, 1'b0, NO_HDR},
            '{8'hF2, 1'b0, 1'b0, NO_HDR}, '{8'h08, 1'b0, 1'b0, NO_HDR},
            '{8'hC1, 1'b0, 1'b1, h_m2_free},
            // layer I, then MPEG-1 layer II at the top rate
            '{8'hFF, 1'b0, 1'b0, NO_HDR}, '{8'hFF, 1'b0, 1'b0, NO_HDR},
            '{8'hFD, 1'b0, 1'b0, NO_HDR}, '{8'hE4, 1'b0, 1'b0, NO_HDR},
            '{8'h00, 1'b0, 1'b1, h_m1_l2}
        };

        while (!rst_n) @(posedge clk);

        foreach (dir_tab[i])
            feed_byte(dir_tab[i].data, dir_tab[i].st, dir_tab[i].typed, dir_tab[i].hdr);
        wait_drained();

        mid_drain_done = 1'b0;
        stop_at = n_in + RAND_ITEMS;
        while (n_in < stop_at)
        begin
            if (!mid_drain_done && n_in >= DRAIN_AT)
            begin
                wait_drained();
                mid_drain_done = 1'b1;
            end

            pick = $urandom_range(0, 2);
            ver_b = ($urandom_range(0, 19) == 0) ? VER_BITS_RSVD :
                    (pick == 0) ? 2'b00 : (pick == 1) ? 2'b10 : 2'b11;
            if ($urandom_range(0, 19) == 0)
                lay_b = ($urandom_range(0, 1) == 1) ? mahsp_pkg::LAYER_RSVD :
                                                      mahsp_pkg::LAYER_ONE;
            else
                lay_b = ($urandom_range(0, 1) == 1) ? mahsp_pkg::LAYER_THREE : 2'd2;
            ridx = ($urandom_range(0, 15) == 0) ? mahsp_pkg::RATE_IDX_BAD :
                                                  4'($urandom_range(0, 14));
            fidx = ($urandom_range(0, 15) == 0) ? mahsp_pkg::FREQ_IDX_BAD :
                                                  2'($urandom_range(0, 2));
            pick = $urandom_range(0, 2);
            emph = ($urandom_range(0, 15) == 0) ? mahsp_pkg::EMPH_BAD :
                   (pick == 0) ? 2'd0 : (pick == 1) ? 2'd1 : 2'd3;
            r  = $urandom;
            b1 = {3'b111, ver_b, lay_b, r[0]};
            b2 = {ridx, fidx, r[2:1]};
            b3 = {r[8:3], emph};

            kind = $urandom_range(0, 9);
            if (kind <= 6)
            begin
                feed_byte(mahsp_pkg::SYNC_BYTE, ($urandom_range(0, 5) == 0), 1'b0, NO_HDR);
                feed_byte(b1, ($urandom_range(0, 39) == 0), 1'b0, NO_HDR);
                feed_byte(b2, ($urandom_range(0, 39) == 0), 1'b0, NO_HDR);
                feed_byte(b3, ($urandom_range(0, 39) == 0), 1'b0, NO_HDR);
                nfill = $urandom_range(0, 5);
            end
            else if (kind == 7)
            begin
                // truncated header
                feed_byte(mahsp_pkg::SYNC_BYTE, 1'b0, 1'b0, NO_HDR);
                feed_byte(b1, 1'b0, 1'b0, NO_HDR);
                if ($urandom_range(0, 1) == 1)
                    feed_byte(b2, 1'b0, 1'b0, NO_HDR);
                nfill = $urandom_range(0, 2);
            end
            else
                nfill = $urandom_range(1, 8);

            for (int k = 0; k < nfill; k++)
            begin
                r = $urandom;
                feed_byte(r[7:0], (r[11:8] == 4'hF), 1'b0, NO_HDR);
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("mpeg_audio_header_sync_parse_unit_test: done, clean");
        else
            $display("mpeg_audio_header_sync_parse_unit_test: done, errors");
        $finish;
    end

endmodule
